// File: rtl/ccpp_pkg.sv
// Shared types and constants for the class constant pool parser.
// Holds the tag codes, the parse phase encoding and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccpp_pkg;

    localparam logic [7:0] TAG_UTF8        = 8'h01;
    localparam logic [7:0] TAG_INTEGER     = 8'h03;
    localparam logic [7:0] TAG_FLOAT       = 8'h04;
    localparam logic [7:0] TAG_LONG        = 8'h05;
    localparam logic [7:0] TAG_DOUBLE      = 8'h06;
    localparam logic [7:0] TAG_CLASS       = 8'h07;
    localparam logic [7:0] TAG_STRING      = 8'h08;
    localparam logic [7:0] TAG_FIELDREF    = 8'h09;
    localparam logic [7:0] TAG_METHODREF   = 8'h0a;
    localparam logic [7:0] TAG_IFMETHODREF = 8'h0b;
    localparam logic [7:0] TAG_NAMETYPE    = 8'h0c;
    localparam logic [7:0] TAG_MHANDLE     = 8'h0f;
    localparam logic [7:0] TAG_MTYPE       = 8'h10;
    localparam logic [7:0] TAG_INDY        = 8'h12;

    localparam int DATA_W = 176;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_CNT_LO   = 7'b0000010,
        PH_TAG      = 7'b0000100,
        PH_PAYLOAD  = 7'b0001000,
        PH_UTF_LEN  = 7'b0010000,
        PH_UTF_BODY = 7'b0100000,
        PH_HALT     = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       start_req;
        logic [7:0] data_byte;
    } in_byte_t;

    // The entry record is ordered so that it packs straight into tdata.
    typedef struct packed {
        logic [15:0] utf8_length;
        logic [63:0] numeric_value;
        logic [7:0]  handle_kind;
        logic [15:0] second_ref;
        logic [15:0] first_ref;
        logic [31:0] entry_offset;
        logic [7:0]  tag;
        logic [15:0] entry_index;
    } entry_t;

    typedef struct packed {
        logic   status;
        logic   pool_done;
        entry_t ent;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/ccpp_in_reg.sv
// Input register stage of the class constant pool parser.
// Holds one accepted byte until the parser consumes it; uses ccpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccpp_in_reg (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [7:0]          s_tdata,
    input  wire                 s_tuser,
    input  wire                 advance,
    output logic                byte_valid,
    output ccpp_pkg::in_byte_t  byte_out
);
    import ccpp_pkg::*;

    logic     valid_reg;
    in_byte_t byte_reg;

    assign s_tready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign byte_out   = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg.start_req <= s_tuser;
            byte_reg.data_byte <= s_tdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ccpp_parser.sv
// Parse state and per-byte step logic of the class constant pool parser.
// Updates the pool walk on each consumed byte and forms the result; uses ccpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccpp_parser (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 byte_valid,
    input  ccpp_pkg::in_byte_t  byte_in,
    input  wire                 advance,
    output logic                load,
    output logic                res_valid,
    output ccpp_pkg::result_t   res
);
    import ccpp_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic [15:0] count_reg,    count_next;
    logic [15:0] index_reg,    index_next;
    logic [15:0] left_reg,     left_next;
    logic [31:0] offset_reg,   offset_next;
    logic [31:0] tag_off_reg,  tag_off_next;
    logic [7:0]  tag_reg,      tag_next;
    logic [63:0] value_reg,    value_next;
    logic [15:0] href_reg,     href_next;
    logic [7:0]  hkind_reg,    hkind_next;

    logic [7:0]  b;
    logic [31:0] offset_inc;
    logic [15:0] left_dec;
    logic [15:0] count_full;
    logic [16:0] index_sum;
    logic        wide_tag;
    logic        done_w;

    function automatic result_t finish(input logic [7:0] t, input logic [63:0] v,
                                       input logic [15:0] href, input logic [7:0] hkind,
                                       input logic [15:0] idx, input logic [31:0] toff,
                                       input logic done);
        result_t r;
        r = '0;
        r.ent.entry_index  = idx;
        r.ent.tag          = t;
        r.ent.entry_offset = toff;
        case (t)
            TAG_UTF8: begin
                r.ent.utf8_length = href;
            end
            TAG_INTEGER, TAG_FLOAT: begin
                r.ent.numeric_value = {32'd0, v[31:0]};
            end
            TAG_LONG, TAG_DOUBLE: begin
                r.ent.numeric_value = v;
            end
            TAG_CLASS, TAG_STRING, TAG_MTYPE: begin
                r.ent.first_ref = v[15:0];
            end
            TAG_MHANDLE: begin
                r.ent.first_ref   = v[15:0];
                r.ent.handle_kind = hkind;
            end
            default: begin
                r.ent.first_ref  = v[31:16];
                r.ent.second_ref = v[15:0];
            end
        endcase
        r.pool_done = done;
        return r;
    endfunction

    assign load       = byte_valid && advance;
    assign b          = byte_in.data_byte;
    assign offset_inc = offset_reg + 32'd1;
    assign left_dec   = left_reg - 16'd1;
    assign count_full = {count_reg[15:8], b};
    assign wide_tag   = (tag_reg == TAG_LONG) || (tag_reg == TAG_DOUBLE);
    assign index_sum  = {1'b0, index_reg} + (wide_tag ? 17'd2 : 17'd1);
    assign done_w     = index_sum >= {1'b0, count_reg};

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        index_next   = index_reg;
        left_next    = left_reg;
        offset_next  = offset_reg;
        tag_off_next = tag_off_reg;
        tag_next     = tag_reg;
        value_next   = value_reg;
        href_next    = href_reg;
        hkind_next   = hkind_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (byte_valid && byte_in.start_req) begin
            count_next   = {b, 8'd0};
            offset_next  = 32'd1;
            index_next   = 16'd0;
            left_next    = 16'd0;
            tag_off_next = 32'd0;
            tag_next     = 8'd0;
            value_next   = 64'd0;
            href_next    = 16'd0;
            hkind_next   = 8'd0;
            phase_next   = PH_CNT_LO;
        end else if (byte_valid) begin
            case (phase_reg)
                PH_CNT_LO: begin
                    count_next  = count_full;
                    offset_next = offset_inc;
                    index_next  = 16'd1;
                    if (count_full <= 16'd1) begin
                        res_valid            = 1'b1;
                        res.ent.entry_offset = 32'd2;
                        res.pool_done        = 1'b1;
                        phase_next           = PH_HALT;
                    end else begin
                        phase_next = PH_TAG;
                    end
                end
                PH_TAG: begin
                    tag_off_next = offset_reg;
                    offset_next  = offset_inc;
                    tag_next     = b;
                    value_next   = 64'd0;
                    href_next    = 16'd0;
                    hkind_next   = 8'd0;
                    phase_next   = PH_PAYLOAD;
                    case (b)
                        TAG_UTF8: begin
                            left_next  = 16'd2;
                            phase_next = PH_UTF_LEN;
                        end
                        TAG_INTEGER, TAG_FLOAT: begin
                            left_next = 16'd4;
                        end
                        TAG_LONG, TAG_DOUBLE: begin
                            left_next = 16'd8;
                        end
                        TAG_CLASS, TAG_STRING, TAG_MTYPE: begin
                            left_next = 16'd2;
                        end
                        TAG_MHANDLE: begin
                            left_next = 16'd3;
                        end
                        TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHODREF, TAG_NAMETYPE,
                        TAG_INDY: begin
                            left_next = 16'd4;
                        end
                        default: begin
                            res_valid            = 1'b1;
                            res.ent.entry_index  = index_reg;
                            res.ent.tag          = b;
                            res.ent.entry_offset = offset_reg;
                            res.status           = 1'b1;
                            res.pool_done        = 1'b1;
                            phase_next           = PH_HALT;
                        end
                    endcase
                end
                PH_PAYLOAD: begin
                    offset_next = offset_inc;
                    if (tag_reg == TAG_MHANDLE && left_reg == 16'd3) begin
                        hkind_next = b;
                    end
                    value_next = {value_reg[55:0], b};
                    left_next  = left_dec;
                    if (left_dec == 16'd0) begin
                        res_valid  = 1'b1;
                        res        = finish(tag_reg, value_next, href_reg, hkind_next,
                                            index_reg, tag_off_reg, done_w);
                        index_next = index_sum[15:0];
                        phase_next = done_w ? PH_HALT : PH_TAG;
                    end
                end
                PH_UTF_LEN: begin
                    offset_next = offset_inc;
                    value_next  = {value_reg[55:0], b};
                    left_next   = left_dec;
                    if (left_dec == 16'd0) begin
                        href_next = value_next[15:0];
                        if (value_next[15:0] == 16'd0) begin
                            res_valid  = 1'b1;
                            res        = finish(tag_reg, value_next, 16'd0, hkind_reg,
                                                index_reg, tag_off_reg, done_w);
                            index_next = index_sum[15:0];
                            phase_next = done_w ? PH_HALT : PH_TAG;
                        end else begin
                            left_next  = value_next[15:0];
                            phase_next = PH_UTF_BODY;
                        end
                    end
                end
                PH_UTF_BODY: begin
                    offset_next = offset_inc;
                    left_next   = left_dec;
                    if (left_dec == 16'd0) begin
                        res_valid  = 1'b1;
                        res        = finish(tag_reg, value_reg, href_reg, hkind_reg,
                                            index_reg, tag_off_reg, done_w);
                        index_next = index_sum[15:0];
                        phase_next = done_w ? PH_HALT : PH_TAG;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (load) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            count_reg   <= count_next;
            index_reg   <= index_next;
            left_reg    <= left_next;
            offset_reg  <= offset_next;
            tag_off_reg <= tag_off_next;
            tag_reg     <= tag_next;
            value_reg   <= value_next;
            href_reg    <= href_next;
            hkind_reg   <= hkind_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ccpp_out_reg.sv
// Result register stage of the class constant pool parser.
// Holds one result until the downstream side takes it; uses ccpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccpp_out_reg (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 load,
    input  wire                 res_valid,
    input  ccpp_pkg::result_t   res,
    input  wire                 m_tready,
    output logic                m_tvalid,
    output ccpp_pkg::result_t   res_out,
    output logic                advance
);
    import ccpp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign advance  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= res_valid;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// File: rtl/class_constant_pool_parser.sv
// Top level of the class constant pool parser: input register, parser, result register.
// Depends on ccpp_pkg, ccpp_in_reg, ccpp_parser and ccpp_out_reg.
//
// Channel  Dir  tdata                         tuser       tlast
// s_       in   data_byte[7:0]                start_req   -
// m_       out  entry record, 176 bits        status      pool_done
//
// One byte is consumed per cycle while the result side does not stall; a result is
// registered in the result register when the parser consumes its last byte.
// The parse state is updated by a single step between the input and result registers.
// Reset clears the handshake state and returns the parser to waiting for a start byte.
// A stall on the result side holds the result and blocks the input only once both
// registers are full.
`timescale 1ns / 1ps
`default_nettype none

module class_constant_pool_parser (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    input  wire  [7:0]                s_tdata,   // data_byte[7:0]
    input  wire                       s_tuser,   // start_req
    output logic                      m_tvalid,
    input  wire                       m_tready,
    // entry_index[15:0], tag[23:16], entry_offset[55:24], first_ref[71:56],
    // second_ref[87:72], handle_kind[95:88], numeric_value[159:96],
    // utf8_length[175:160]
    output logic [ccpp_pkg::DATA_W-1:0] m_tdata,
    output logic                      m_tuser,   // status
    output logic                      m_tlast    // pool_done
);
    import ccpp_pkg::*;

    logic     advance;
    logic     byte_valid;
    in_byte_t byte_w;
    logic     load;
    logic     res_valid;
    result_t  res_w;
    result_t  res_out;

    ccpp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_out   (byte_w)
    );

    ccpp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .byte_in    (byte_w),
        .advance    (advance),
        .load       (load),
        .res_valid  (res_valid),
        .res        (res_w)
    );

    ccpp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .res_valid (res_valid),
        .res       (res_w),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .res_out   (res_out),
        .advance   (advance)
    );

    assign m_tdata = res_out.ent;
    assign m_tuser = res_out.status;
    assign m_tlast = res_out.pool_done;

    a_error_ends_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_out.status |-> res_out.pool_done)
        else $error("unknown-tag result without pool end");

    a_empty_pool_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res_out.status && res_out.ent.tag == 8'd0 |->
            res_out.ent.entry_index == 16'd0 && res_out.ent.entry_offset == 32'd2 &&
            res_out.pool_done)
        else $error("malformed empty-pool result");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked while result register is empty");

    a_result_from_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(byte_valid))
        else $error("result without a consumed byte");

endmodule

`default_nettype wire
